/* hw/rtl/point_plane_signed_distance_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the point to plane signed distance core
// Implication checks on the core clock, held off during reset.
// ---------------------------------------------------------------------------
`ifndef POINT_PLANE_SIGNED_DISTANCE_CORE_ASSERT_SVH
`define POINT_PLANE_SIGNED_DISTANCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PPSD_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ppsd assertion failed");
`define PPSD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ppsd assertion failed");
`else
`define PPSD_ASSERT_IMPLY(lbl, ante, cons)
`define PPSD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/ppsd_pkg.sv */
// ---------------------------------------------------------------------------
// Point to plane signed distance package
// Widths, shared types and result limits.
// ---------------------------------------------------------------------------
package ppsd_pkg;
   localparam int CoordW = 24;
   localparam int NumIn  = 12;
   localparam int DiffW  = 25;
   localparam int ProdW  = 50;
   localparam int NormW  = 51;
   localparam int ChunkW = 26;
   localparam int DotLoW = 52;
   localparam int DotW   = 78;
   localparam int MagW   = 77;
   localparam int Len2W  = 102;
   localparam int Dot2W  = 156;
   localparam int QW     = 25;
   localparam int AccW   = 160;
   localparam int RW     = 128;

   localparam logic [CoordW-1:0] DistMax = 24'h7FFFFF;
   localparam logic [CoordW-1:0] DistMin = 24'h800000;
   localparam logic [QW-1:0]     QMaxPos = 25'd8388607;
   localparam logic [QW-1:0]     QMaxNeg = 25'd8388608;

   typedef struct packed {
      logic [Len2W-1:0] len2;
      logic [Dot2W-1:0] dot2;
      logic             neg;
      logic             deg;
   } ppsd_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ppsd_qstat_type;
endpackage

/* hw/rtl/ppsd_front.sv */
// ---------------------------------------------------------------------------
// Front pipeline
// Forms edges, normal, dot product, squared norm and squared dot.
// ---------------------------------------------------------------------------
module ppsd_front (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic [ppsd_pkg::NumIn*ppsd_pkg::CoordW-1:0] in_data,
   input  ppsd_pkg::ppsd_qstat_type                    qstat,
   output logic                                        push,
   output ppsd_pkg::ppsd_job_type                      job
);
   import ppsd_pkg::*;
   localparam int Stages = 8;

   logic                     adv;
   logic [Stages-1:0]        vld_ff, vld_in;
   logic signed [CoordW-1:0] crd [NumIn];
   logic signed [DiffW-1:0]  u_in [3], v_in [3], w_in [3];
   logic signed [DiffW-1:0]  u_ff [3], v_ff [3], w1_ff [3], w2_ff [3], w3_ff [3];
   logic signed [ProdW-1:0]  p_in [6], p_ff [6];
   logic signed [NormW-1:0]  n_in [3], n_ff [3];
   logic signed [DotLoW-1:0] dl_in [3], dl_ff [3];
   logic signed [ProdW-1:0]  dh_in [3], dh_ff [3];
   logic [NormW-1:0]         nmag_in [3], nmag_ff [3];
   logic signed [DotW-1:0]   dot_in, dot_ff;
   logic [2*ChunkW-1:0]      s00_in [3], s01_in [3], s11_in [3];
   logic [2*ChunkW-1:0]      s00_ff [3], s01_ff [3], s11_ff [3];
   logic [Len2W-1:0]         sqc_in [3], sqc_ff [3];
   logic [MagW-1:0]          mag_in, mag_ff;
   logic                     neg6_in, neg6_ff, neg7_ff;
   logic [Len2W-1:0]         len2_in, len2_ff;
   logic [2*ChunkW-1:0]      pp_in [6], pp_ff [6];
   ppsd_job_type             job_in, job_ff;

   assign adv      = !vld_ff[Stages-1] || !qstat.full;
   assign in_ready = adv;
   assign push     = vld_ff[Stages-1] && !qstat.full;
   assign job      = job_ff;
   assign vld_in   = {vld_ff[Stages-2:0], in_valid};

   always_comb begin
      for (int i = 0; i < NumIn; i++) begin
         crd[i] = in_data[i*CoordW +: CoordW];
      end
      for (int k = 0; k < 3; k++) begin
         u_in[k] = DiffW'(crd[6+k]) - DiffW'(crd[3+k]);
         v_in[k] = DiffW'(crd[9+k]) - DiffW'(crd[3+k]);
         w_in[k] = DiffW'(crd[k]) - DiffW'(crd[3+k]);
      end
      p_in[0] = ProdW'(u_ff[1]) * ProdW'(v_ff[2]);
      p_in[1] = ProdW'(u_ff[2]) * ProdW'(v_ff[1]);
      p_in[2] = ProdW'(u_ff[2]) * ProdW'(v_ff[0]);
      p_in[3] = ProdW'(u_ff[0]) * ProdW'(v_ff[2]);
      p_in[4] = ProdW'(u_ff[0]) * ProdW'(v_ff[1]);
      p_in[5] = ProdW'(u_ff[1]) * ProdW'(v_ff[0]);
      for (int k = 0; k < 3; k++) begin
         n_in[k]    = NormW'(p_ff[2*k]) - NormW'(p_ff[2*k+1]);
         dl_in[k]   = DotLoW'($signed({1'b0, n_ff[k][ChunkW-1:0]})) * DotLoW'(w3_ff[k]);
         dh_in[k]   = ProdW'($signed(n_ff[k][NormW-1:ChunkW])) * ProdW'(w3_ff[k]);
         nmag_in[k] = n_ff[k][NormW-1] ? NormW'(-n_ff[k]) : NormW'(n_ff[k]);
         s00_in[k]  = (2*ChunkW)'(nmag_ff[k][ChunkW-1:0]) *
                      (2*ChunkW)'(nmag_ff[k][ChunkW-1:0]);
         s01_in[k]  = (2*ChunkW)'(nmag_ff[k][ChunkW-1:0]) *
                      (2*ChunkW)'(nmag_ff[k][NormW-1:ChunkW]);
         s11_in[k]  = (2*ChunkW)'(nmag_ff[k][NormW-1:ChunkW]) *
                      (2*ChunkW)'(nmag_ff[k][NormW-1:ChunkW]);
         sqc_in[k]  = Len2W'(s00_ff[k]) + (Len2W'(s01_ff[k]) << (ChunkW+1)) +
                      (Len2W'(s11_ff[k]) << (2*ChunkW));
      end
      dot_in = '0;
      for (int k = 0; k < 3; k++) begin
         dot_in = dot_in + (DotW'(dh_ff[k]) << ChunkW) + DotW'(dl_ff[k]);
      end
      neg6_in = dot_ff[DotW-1];
      mag_in  = dot_ff[DotW-1] ? MagW'(-dot_ff) : MagW'(dot_ff);
      len2_in = sqc_ff[0] + sqc_ff[1] + sqc_ff[2];
      pp_in[0] = (2*ChunkW)'(mag_ff[25:0])  * (2*ChunkW)'(mag_ff[25:0]);
      pp_in[1] = (2*ChunkW)'(mag_ff[25:0])  * (2*ChunkW)'(mag_ff[51:26]);
      pp_in[2] = (2*ChunkW)'(mag_ff[25:0])  * (2*ChunkW)'(mag_ff[76:52]);
      pp_in[3] = (2*ChunkW)'(mag_ff[51:26]) * (2*ChunkW)'(mag_ff[51:26]);
      pp_in[4] = (2*ChunkW)'(mag_ff[51:26]) * (2*ChunkW)'(mag_ff[76:52]);
      pp_in[5] = (2*ChunkW)'(mag_ff[76:52]) * (2*ChunkW)'(mag_ff[76:52]);
      job_in.len2 = len2_ff;
      job_in.dot2 = Dot2W'(pp_ff[0]) + (Dot2W'(pp_ff[1]) << (ChunkW+1)) +
                    (((Dot2W'(pp_ff[2]) << 1) + Dot2W'(pp_ff[3])) << (2*ChunkW)) +
                    (Dot2W'(pp_ff[4]) << (3*ChunkW+1)) + (Dot2W'(pp_ff[5]) << (4*ChunkW));
      job_in.neg  = neg7_ff;
      job_in.deg  = (len2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            u_ff[k]    <= u_in[k];
            v_ff[k]    <= v_in[k];
            w1_ff[k]   <= w_in[k];
            w2_ff[k]   <= w1_ff[k];
            w3_ff[k]   <= w2_ff[k];
            n_ff[k]    <= n_in[k];
            dl_ff[k]   <= dl_in[k];
            dh_ff[k]   <= dh_in[k];
            nmag_ff[k] <= nmag_in[k];
            s00_ff[k]  <= s00_in[k];
            s01_ff[k]  <= s01_in[k];
            s11_ff[k]  <= s11_in[k];
            sqc_ff[k]  <= sqc_in[k];
         end
         for (int k = 0; k < 6; k++) begin
            p_ff[k]  <= p_in[k];
            pp_ff[k] <= pp_in[k];
         end
         dot_ff  <= dot_in;
         mag_ff  <= mag_in;
         neg6_ff <= neg6_in;
         neg7_ff <= neg6_ff;
         len2_ff <= len2_in;
         job_ff  <= job_in;
      end
   end
endmodule

/* hw/rtl/ppsd_queue.sv */
// ---------------------------------------------------------------------------
// Job queue
// Short register FIFO between the front and back pipelines.
// ---------------------------------------------------------------------------
module ppsd_queue #(
   parameter int Depth = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ppsd_pkg::ppsd_job_type   wr_job,
   input  logic                     pop,
   output ppsd_pkg::ppsd_job_type   rd_job,
   output ppsd_pkg::ppsd_qstat_type qstat
);
   import ppsd_pkg::*;
   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   ppsd_job_type    mem_ff [Depth];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign rd_job      = mem_ff[rd_ff];
   assign qstat.full  = (cnt_ff == FullCnt);
   assign qstat.empty = (cnt_ff == '0);

   always_comb begin
      wr_in  = push ? ((wr_ff == LastPtr) ? '0 : wr_ff + PtrW'(1)) : wr_ff;
      rd_in  = pop ? ((rd_ff == LastPtr) ? '0 : rd_ff + PtrW'(1)) : rd_ff;
      cnt_in = cnt_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wr_job;
      end
   end
endmodule

/* hw/rtl/ppsd_back.sv */
// ---------------------------------------------------------------------------
// Back pipeline
// Bit-per-stage quotient search and output clamp.
// ---------------------------------------------------------------------------
module ppsd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ppsd_pkg::ppsd_job_type        job,
   input  ppsd_pkg::ppsd_qstat_type      qstat,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [ppsd_pkg::CoordW-1:0]   out_dist,
   output logic                          out_deg,
   output logic                          out_sat
);
   import ppsd_pkg::*;

   typedef struct packed {
      logic [Len2W-1:0] len2;
      logic [Dot2W-1:0] dot2;
      logic [AccW-1:0]  acc;
      logic [RW-1:0]    r;
      logic [QW-1:0]    q;
      logic             neg;
      logic             deg;
   } ppsd_stage_type;

   logic              adv;
   logic [QW:0]       vld_ff;
   ppsd_stage_type    st_ff [0:QW];
   ppsd_stage_type    st_in [1:QW];
   ppsd_stage_type    st0_in;
   logic              ov_ff;
   logic [CoordW-1:0] dist_ff, dist_in;
   logic              deg_ff, deg_in, sat_ff, sat_in;
   logic [QW-1:0]     qf;

   assign adv       = !ov_ff || out_ready;
   assign pop       = adv && !qstat.empty;
   assign out_valid = ov_ff;
   assign out_dist  = dist_ff;
   assign out_deg   = deg_ff;
   assign out_sat   = sat_ff;

   always_comb begin
      st0_in.len2 = job.len2;
      st0_in.dot2 = job.dot2;
      st0_in.acc  = '0;
      st0_in.r    = '0;
      st0_in.q    = '0;
      st0_in.neg  = job.neg;
      st0_in.deg  = job.deg;
   end

   for (genvar k = 1; k <= QW; k++) begin : g_bit
      localparam int B = QW - k;
      logic [AccW-1:0] cand;
      logic            take;
      ppsd_stage_type  nxt;
      always_comb begin
         cand = st_ff[k-1].acc + (AccW'(st_ff[k-1].r) << (B + 1)) +
                (AccW'(st_ff[k-1].len2) << (2 * B));
         take = (cand <= AccW'(st_ff[k-1].dot2));
         nxt  = st_ff[k-1];
         if (take) begin
            nxt.acc  = cand;
            nxt.r    = st_ff[k-1].r + (RW'(st_ff[k-1].len2) << B);
            nxt.q[B] = 1'b1;
         end
      end
      assign st_in[k] = nxt;
   end

   always_comb begin
      qf      = st_ff[QW].q;
      dist_in = '0;
      deg_in  = 1'b0;
      sat_in  = 1'b0;
      if (st_ff[QW].deg) begin
         deg_in = 1'b1;
      end else if (st_ff[QW].neg) begin
         if (qf > QMaxNeg) begin
            dist_in = DistMin;
            sat_in  = 1'b1;
         end else begin
            dist_in = CoordW'(-qf);
         end
      end else begin
         if (qf > QMaxPos) begin
            dist_in = DistMax;
            sat_in  = 1'b1;
         end else begin
            dist_in = qf[CoordW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         ov_ff  <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[QW-1:0], !qstat.empty};
         ov_ff  <= vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= st0_in;
         for (int k = 1; k <= QW; k++) begin
            st_ff[k] <= st_in[k];
         end
         dist_ff <= dist_in;
         deg_ff  <= deg_in;
         sat_ff  <= sat_in;
      end
   end
endmodule

/* hw/rtl/point_plane_signed_distance_core.sv */
// ---------------------------------------------------------------------------
// Point to plane signed distance core
// Signed Q12.12 distance of a point from the plane of a triangle.
// ---------------------------------------------------------------------------
// Usage:
//   The req channel carries one query per request: point, then vertices a,
//   b and c, each coordinate a 24-bit signed Q12.12 value. The rsp channel
//   returns the distance in rsp_tdata and the degenerate and saturated flags
//   in rsp_tuser, one response per request, in order.
//   Without stalls, a request passes 7 front stages after the input
//   register, one queue slot, one job register, 25 quotient stages (one
//   quotient bit each) and the output register.
//   Throughput is one request per cycle while the receiver takes responses.
//   When the receiver stalls, the back pipeline holds; the front keeps
//   taking requests until the queue between them fills, then deasserts
//   req_tready. Reset empties both pipelines and the queue; no clearing
//   pass is needed.
// ---------------------------------------------------------------------------
`include "point_plane_signed_distance_core_assert.svh"

module point_plane_signed_distance_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // signed_distance
   output logic [23:0]  rsp_tdata,
   // degenerate, saturated
   output logic [1:0]   rsp_tuser
);
   import ppsd_pkg::*;

   logic           push, pop;
   ppsd_job_type   wr_job, rd_job;
   ppsd_qstat_type qstat;
   logic           deg, sat;

   ppsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_data  (req_tdata),
      .qstat    (qstat),
      .push     (push),
      .job      (wr_job)
   );

   ppsd_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_job (wr_job),
      .pop    (pop),
      .rd_job (rd_job),
      .qstat  (qstat)
   );

   ppsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (rd_job),
      .qstat     (qstat),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_dist  (rsp_tdata),
      .out_deg   (deg),
      .out_sat   (sat)
   );

   assign rsp_tuser = {sat, deg};

   `PPSD_ASSERT_IMPLY(a_push_room, push, !qstat.full)
   `PPSD_ASSERT_NEXT(a_push_fills, push, !qstat.empty)
   `PPSD_ASSERT_IMPLY(a_deg_zero, rsp_tvalid && deg, rsp_tdata == '0 && !sat)
   `PPSD_ASSERT_IMPLY(a_sat_clamp, rsp_tvalid && sat, rsp_tdata == DistMax || rsp_tdata == DistMin)
endmodule

/* dv/tb_top.sv */
// ---------------------------------------------------------------------------
// Point to plane signed distance core testbench
// Streams random and corner-case point and triangle requests through the
// core with random gaps and stalls on both sides, predicts each distance
// and flag pair in exact integer arithmetic and checks every response.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import ppsd_pkg::*;

   localparam int RandomItems = 2000;
   localparam int Latency     = 35;
   localparam int IdleLimit   = 20000;

   typedef struct packed {
      logic [CoordW-1:0] signed_distance;
      logic              degenerate;
      logic              saturated;
   } dist_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [287:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [23:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   logic [287:0]    query_queue[$];
   dist_result_type expected_distances[$];
   int              mismatch_count;
   int              send_gap;
   int              recv_gap;
   int              idle_cycles;
   int              sent_count;
   bit              hold_rsp;
   bit              hold_done;
   bit              drain_pause;
   bit              stim_done;

   point_plane_signed_distance_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic void queue_query(logic [287:0] q);
      query_queue.insert(query_queue.size(), q);
   endfunction

   function automatic logic signed [23:0] coord(logic [287:0] q, int idx);
      return q[idx*24 +: 24];
   endfunction

   function automatic dist_result_type plane_distance(logic [287:0] q);
      logic signed [24:0]  ux, uy, uz, vx, vy, vz, wx, wy, wz;
      logic signed [103:0] nx, ny, nz;
      logic signed [79:0]  dot;
      logic [79:0]         mag;
      logic [103:0]        len2;
      logic [159:0]        dot2;
      logic [159:0]        lhs;
      logic [24:0]         quo;
      logic [24:0]         trial;
      dist_result_type     r;
      ux = coord(q, 6) - coord(q, 3);
      uy = coord(q, 7) - coord(q, 4);
      uz = coord(q, 8) - coord(q, 5);
      vx = coord(q, 9) - coord(q, 3);
      vy = coord(q, 10) - coord(q, 4);
      vz = coord(q, 11) - coord(q, 5);
      wx = coord(q, 0) - coord(q, 3);
      wy = coord(q, 1) - coord(q, 4);
      wz = coord(q, 2) - coord(q, 5);
      nx = uy * vz - uz * vy;
      ny = uz * vx - ux * vz;
      nz = ux * vy - uy * vx;
      r = '0;
      if (nx == 0 && ny == 0 && nz == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      len2 = nx * nx + ny * ny + nz * nz;
      dot = 80'(nx * wx + ny * wy + nz * wz);
      mag = dot[79] ? 80'(-dot) : 80'(dot);
      dot2 = 160'(mag) * 160'(mag);
      quo = '0;
      for (int b = 24; b >= 0; b--) begin
         trial = quo | (25'd1 << b);
         lhs = 160'(trial) * 160'(trial) * 160'(len2);
         if (lhs <= dot2) quo = trial;
      end
      if (dot[79]) begin
         if (quo > QMaxNeg) begin
            quo = QMaxNeg;
            r.saturated = 1'b1;
         end
         r.signed_distance = 24'(-quo);
      end else begin
         if (quo > QMaxPos) begin
            quo = QMaxPos;
            r.saturated = 1'b1;
         end
         r.signed_distance = quo[23:0];
      end
      return r;
   endfunction

   function automatic logic [23:0] rand_coord(int span);
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return 24'(int'($urandom_range(0, 2 * span)) - span);
         2: return $urandom_range(0, 1) ? DistMax : DistMin;
         default: return 24'(int'($urandom_range(0, 8)) - 4);
      endcase
   endfunction

   function automatic logic [287:0] rand_query();
      logic [287:0] q;
      int span;
      span = 1 << $urandom_range(4, 23);
      for (int i = 0; i < NumIn; i++) q[i*24 +: 24] = rand_coord(span);
      if ($urandom_range(0, 9) == 0) begin
         // collinear vertices: c = a + k * (b - a)
         for (int i = 0; i < 3; i++)
            q[(9+i)*24 +: 24] = q[(3+i)*24 +: 24]
               + 24'(2 * (q[(6+i)*24 +: 24] - q[(3+i)*24 +: 24]));
      end
      return q;
   endfunction

   function automatic logic [287:0] pack_query(int p[3], int a[3], int b[3], int c[3]);
      logic [287:0] q;
      for (int i = 0; i < 3; i++) begin
         q[i*24 +: 24]     = 24'(p[i]);
         q[(3+i)*24 +: 24] = 24'(a[i]);
         q[(6+i)*24 +: 24] = 24'(b[i]);
         q[(9+i)*24 +: 24] = 24'(c[i]);
      end
      return q;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      int one;
      one = 4096;
      // unit triangle in z = 0, point above, below and far away
      queue_query(pack_query('{0, 0, one}, '{0, 0, 0}, '{one, 0, 0}, '{0, one, 0}));
      queue_query(pack_query('{5, 7, -one}, '{0, 0, 0}, '{one, 0, 0}, '{0, one, 0}));
      queue_query(pack_query('{0, 0, 8388607}, '{0, 0, -8388608},
         '{one, 0, -8388608}, '{0, one, -8388608}));
      queue_query(pack_query('{0, 0, -8388608}, '{0, 0, 8388607},
         '{one, 0, 8388607}, '{0, one, 8388607}));
      // all extremes
      queue_query(pack_query('{8388607, -8388608, 8388607},
         '{-8388608, -8388608, -8388608}, '{8388607, -8388608, 8388607},
         '{-8388608, 8388607, 8388607}));
      queue_query(pack_query('{-8388608, 8388607, -8388608},
         '{8388607, 8388607, 8388607}, '{-8388608, 8388607, -8388608},
         '{8388607, -8388608, -8388608}));
      // degenerate: coincident and collinear vertices, all zero
      queue_query(pack_query('{1, 2, 3}, '{9, 9, 9}, '{9, 9, 9}, '{4, 5, 6}));
      queue_query(pack_query('{1, 2, 3}, '{0, 0, 0}, '{1, 1, 1}, '{2, 2, 2}));
      queue_query(pack_query('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}));
      // point on the plane, tiny triangle with a large offset
      queue_query(pack_query('{100, 200, 0}, '{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}));
      queue_query(pack_query('{0, 0, 3}, '{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}));
      queue_query(pack_query('{-1, -1, -1}, '{-1, -1, -1}, '{8388607, 0, 0},
         '{0, 8388607, 0}));
      // every bit at both values
      queue_query({12{24'hAAAAAA}});
      queue_query({12{24'h555555}});
      for (int i = 0; i < RandomItems; i++) queue_query(rand_query());
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
         sent_count <= 0;
         drain_pause <= 1'b0;
         stim_done  <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) sent_count <= sent_count + 1;
         if (drain_pause) begin
            req_tvalid <= 1'b0;
            if (expected_distances.size() == 0 && !req_tvalid) drain_pause <= 1'b0;
         end else if (sent_count == 1000 && req_tvalid) begin
            req_tvalid  <= 1'b0;
            drain_pause <= 1'b1;
         end else if (send_gap > 0 && !hold_rsp) begin
            req_tvalid <= 1'b0;
            send_gap   <= send_gap - 1;
         end else if (query_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= query_queue.pop_front();
            send_gap   <= (sent_count > 200 && sent_count < 400) ? 0 : pick_gap();
         end else begin
            req_tvalid <= 1'b0;
            stim_done  <= 1'b1;
         end
      end
   end

   // response receiver and checker
   always @(posedge clock) begin
      dist_result_type got;
      dist_result_type want;
      if (reset) begin
         rsp_tready     <= 1'b0;
         recv_gap       <= 0;
         hold_rsp       <= 1'b0;
         hold_done      <= 1'b0;
         mismatch_count <= 0;
         idle_cycles    <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_distances.insert(expected_distances.size(), plane_distance(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata, rsp_tuser[0], rsp_tuser[1]};
            if (expected_distances.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected response %h flags %b", rsp_tdata, rsp_tuser);
            end else begin
               want = expected_distances.pop_front();
               if (got !== want) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("mismatch: dist exp %h got %h, deg exp %b got %b, sat exp %b got %b",
                        want.signed_distance, got.signed_distance, want.degenerate,
                        got.degenerate, want.saturated, got.saturated);
               end
            end
         end
         idle_cycles <= ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) ? 0
            : idle_cycles + 1;
         // long hold-off so the queue fills and req_tready drops
         if (sent_count >= 300 && !hold_done) begin
            hold_rsp   <= 1'b1;
            hold_done  <= 1'b1;
            recv_gap   <= 200;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap   <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            hold_rsp   <= 1'b0;
            rsp_tready <= 1'b1;
            if (!hold_rsp && sent_count > 100 && (sent_count < 1500 || sent_count > 1800))
               recv_gap <= pick_gap();
         end
      end
   end

   initial begin
      wait (stim_done && !reset);
      while (expected_distances.size() > 0 && idle_cycles < IdleLimit) @(posedge clock);
      if (idle_cycles >= IdleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         repeat (Latency + 10) @(posedge clock);
         if (mismatch_count == 0 && expected_distances.size() == 0)
            $display("RESULT: OK");
         else
            $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      wait (!reset);
      wait (idle_cycles >= IdleLimit);
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
